// ===== src/tgad_pkg.sv =====
// ----------------------------------------------------------------------------
// tgad_pkg
// shared types and constants of the tga image stream decoder
// ----------------------------------------------------------------------------
package tgad_pkg;

	// result status codes
	typedef enum logic [2:0] {
		ST_RUN      = 3'd0,
		ST_BAD_TYPE = 3'd1,
		ST_COLORMAP = 3'd2,
		ST_BAD_SIZE = 3'd3,
		ST_TRUNC    = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	// header byte offsets
	localparam logic [4:0] HDR_ID_LEN    = 5'd0;
	localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_BPP       = 5'd16;
	localparam logic [4:0] HDR_ATTR      = 5'd17;
	localparam logic [4:0] HDR_LEN       = 5'd18;

	// image types
	localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
	localparam logic [7:0] IMG_GRAY      = 8'd3;
	localparam logic [7:0] IMG_RLE       = 8'd10;

	// pixel sizes
	localparam logic [7:0] BPP_GRAY = 8'd8;
	localparam logic [7:0] BPP_RGB  = 8'd24;
	localparam logic [7:0] BPP_RGBA = 8'd32;

	// attribute bit for top-down row order
	localparam int ATTR_TOP_DOWN = 5;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

	// one result beat
	typedef struct packed {
		status_t     status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] dest_row;
		logic [15:0] start_column;
		logic [7:0]  run_count;
		logic        rows_ascend;
		logic        last;
	} run_t;

endpackage

// ===== src/tgad_byte_if.sv =====
// ----------------------------------------------------------------------------
// tgad_byte_if
// file byte channel: one byte of the tga file per beat
// ----------------------------------------------------------------------------
interface tgad_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;
	logic       file_end;

	modport source (output valid, output data_byte, output file_start, output file_end,
		input ready);
	modport sink (input valid, input data_byte, input file_start, input file_end,
		output ready);
endinterface

// ===== src/tgad_run_if.sv =====
// ----------------------------------------------------------------------------
// tgad_run_if
// result channel: one rgba pixel run or one error status per beat
// ----------------------------------------------------------------------------
interface tgad_run_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [15:0] dest_row;
	logic [15:0] start_column;
	logic [7:0]  run_count;
	logic        rows_ascend;
	logic        last;

	modport source (output valid, output status, output red, output green, output blue,
		output alpha, output dest_row, output start_column, output run_count,
		output rows_ascend, output last, input ready);
	modport sink (input valid, input status, input red, input green, input blue,
		input alpha, input dest_row, input start_column, input run_count,
		input rows_ascend, input last, output ready);
endinterface

// ===== src/tga_image_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_image_stream_decoder
// streaming tga parser: header, image id skip, raw and run-length pixels
// ----------------------------------------------------------------------------
// The decoder takes one byte of a tga file per beat and normally accepts a
// byte on every clock: each byte updates the parse registers through one
// level of logic and, when it completes a pixel, writes a result beat into a
// two-entry output stage (output register plus skid register), so a result
// left waiting on the result channel does not hold up the byte channel until
// both entries are full. Types 2, 3 and 10 with 8 (gray only), 24 or 32 bit
// pixels are decoded. A pixel run that ends two or more rows past its start
// (only run packets on images narrower than 128 pixels) moves the row and
// column through a radix-4 divider, and the byte channel is held not ready
// while the divider runs. A file starts on a beat with file_start set; after
// the last pixel, after an error, and after reset the decoder drops bytes
// until the next file_start. Header faults, an empty image and a file that
// ends early give one error beat with last set. The pixel count w*h is formed
// by one 16x16 multiply on the bits-per-pixel header byte.
// ----------------------------------------------------------------------------
module tga_image_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	tgad_byte_if.sink   bytes,
	tgad_run_if.source  runs
);

	// parse state
	logic [4:0]  hdr_idx_q, n_hdr_idx;
	logic [7:0]  id_skip_q, n_id_skip;
	logic [7:0]  kind_q, n_kind;
	logic [7:0]  cmap_q, n_cmap;
	logic [7:0]  bpp_q, n_bpp;
	logic        flip_q, n_flip;
	logic [15:0] width_q, n_width;
	logic [15:0] height_q, n_height;
	logic [15:0] row_q, n_row;
	logic [15:0] col_q, n_col;
	logic [1:0]  pix_idx_q, n_pix_idx;
	logic [23:0] color_q, n_color;
	logic [7:0]  pkt_left_q, n_pkt_left;
	logic        pkt_run_q, n_pkt_run;
	logic        finished_q, n_finished;
	logic [31:0] pix_left_q, n_pix_left;

	// row wrap divider
	logic        div_busy_q, n_div_busy;
	logic [16:0] div_rem_q, n_div_rem;
	logic [22:0] div_dvs_q, n_div_dvs;
	logic [7:0]  div_quo_q, n_div_quo;
	logic [1:0]  div_cnt_q, n_div_cnt;
	logic        div_ge1, div_ge0;
	logic [16:0] div_r1, div_r0;
	logic [22:0] div_d0;

	// output stage
	logic             out_valid_q, skid_valid_q;
	tgad_pkg::run_t   out_q, skid_q;
	tgad_pkg::run_t   res;
	logic             res_valid;

	// per-byte helpers
	logic             in_fire;
	logic [7:0]       data;
	logic [2:0]       bytes_pp;
	logic [2:0]       idx_inc;
	logic [23:0]      color_v;
	logic [7:0]       cnt;
	logic [16:0]      total, over, width17;
	tgad_pkg::status_t fault;

	function automatic tgad_pkg::run_t error_beat(tgad_pkg::status_t code);
		tgad_pkg::run_t r;
		r        = '0;
		r.status = code;
		r.last   = 1'b1;
		return r;
	endfunction

	function automatic tgad_pkg::status_t hdr_fault(logic [7:0] kind, logic [7:0] cmap,
		logic [7:0] bpp, logic [15:0] w, logic [15:0] h);
		tgad_pkg::status_t s;
		s = tgad_pkg::ST_RUN;
		if (kind != tgad_pkg::IMG_TRUECOLOR && kind != tgad_pkg::IMG_GRAY &&
			kind != tgad_pkg::IMG_RLE) begin
			s = tgad_pkg::ST_BAD_TYPE;
		end else if (cmap != 8'd0) begin
			s = tgad_pkg::ST_COLORMAP;
		end else if (bpp != tgad_pkg::BPP_RGB && bpp != tgad_pkg::BPP_RGBA &&
			!(kind == tgad_pkg::IMG_GRAY && bpp == tgad_pkg::BPP_GRAY)) begin
			s = tgad_pkg::ST_BAD_SIZE;
		end else if (w == 16'd0 || h == 16'd0) begin
			s = tgad_pkg::ST_EMPTY;
		end
		return s;
	endfunction

	// byte channel is held while a skid entry waits or the divider runs
	assign bytes.ready = !skid_valid_q && !div_busy_q;
	assign in_fire     = bytes.valid && bytes.ready;
	assign data        = bytes.data_byte;

	// bytes per pixel, valid once the header has passed its checks
	assign bytes_pp = bpp_q[5:3];
	assign width17  = {1'b0, width_q};
	assign fault    = hdr_fault(kind_q, cmap_q, bpp_q, width_q, height_q);

	// two restoring divide steps per cycle
	assign div_ge1 = {6'd0, div_rem_q} >= div_dvs_q;
	assign div_r1  = div_ge1 ? 17'(div_rem_q - div_dvs_q[16:0]) : div_rem_q;
	assign div_d0  = div_dvs_q >> 1;
	assign div_ge0 = {6'd0, div_r1} >= div_d0;
	assign div_r0  = div_ge0 ? 17'(div_r1 - div_d0[16:0]) : div_r1;

	always_comb begin
		n_hdr_idx  = hdr_idx_q;
		n_id_skip  = id_skip_q;
		n_kind     = kind_q;
		n_cmap     = cmap_q;
		n_bpp      = bpp_q;
		n_flip     = flip_q;
		n_width    = width_q;
		n_height   = height_q;
		n_row      = row_q;
		n_col      = col_q;
		n_pix_idx  = pix_idx_q;
		n_color    = color_q;
		n_pkt_left = pkt_left_q;
		n_pkt_run  = pkt_run_q;
		n_finished = finished_q;
		n_pix_left = pix_left_q;
		n_div_busy = div_busy_q;
		n_div_rem  = div_rem_q;
		n_div_dvs  = div_dvs_q;
		n_div_quo  = div_quo_q;
		n_div_cnt  = div_cnt_q;
		res        = '0;
		res_valid  = 1'b0;
		color_v    = color_q;
		idx_inc    = {1'b0, pix_idx_q} + 3'd1;
		cnt        = 8'd1;
		total      = '0;
		over       = '0;

		// row wrap in progress: quotient goes to the row, remainder to the column
		if (div_busy_q) begin
			n_div_rem = div_r0;
			n_div_dvs = div_dvs_q >> 2;
			n_div_quo = {div_quo_q[5:0], div_ge1, div_ge0};
			n_div_cnt = 2'(div_cnt_q + 2'd1);
			if (div_cnt_q == 2'd3) begin
				n_div_busy = 1'b0;
				n_row      = 16'(row_q + {8'd0, n_div_quo});
				n_col      = div_r0[15:0];
			end
		end

		if (in_fire) begin
			if (bytes.file_start) begin
				n_hdr_idx  = '0;
				n_id_skip  = '0;
				n_kind     = '0;
				n_cmap     = '0;
				n_bpp      = '0;
				n_flip     = 1'b0;
				n_width    = '0;
				n_height   = '0;
				n_row      = '0;
				n_col      = '0;
				n_pix_idx  = '0;
				n_color    = '0;
				n_pkt_left = '0;
				n_pkt_run  = 1'b0;
				n_pix_left = '0;
				n_finished = 1'b0;
			end

			if (!n_finished) begin
				if (n_hdr_idx < tgad_pkg::HDR_LEN) begin
					// header bytes
					case (n_hdr_idx)
						tgad_pkg::HDR_ID_LEN:    n_id_skip = data;
						tgad_pkg::HDR_CMAP_TYPE: n_cmap = data;
						tgad_pkg::HDR_IMG_TYPE:  n_kind = data;
						tgad_pkg::HDR_WIDTH_LO:  n_width = {width_q[15:8], data};
						tgad_pkg::HDR_WIDTH_HI:  n_width = {data, width_q[7:0]};
						tgad_pkg::HDR_HEIGHT_LO: n_height = {height_q[15:8], data};
						tgad_pkg::HDR_HEIGHT_HI: n_height = {data, height_q[7:0]};
						tgad_pkg::HDR_BPP: begin
							n_bpp      = data;
							n_pix_left = width_q * height_q;
						end
						tgad_pkg::HDR_ATTR:      n_flip = data[tgad_pkg::ATTR_TOP_DOWN];
						default: ;
					endcase
					if (n_hdr_idx == tgad_pkg::HDR_ATTR &&
						fault != tgad_pkg::ST_RUN) begin
						res        = error_beat(fault);
						res_valid  = 1'b1;
						n_finished = 1'b1;
					end else if (bytes.file_end) begin
						res        = error_beat(tgad_pkg::ST_TRUNC);
						res_valid  = 1'b1;
						n_finished = 1'b1;
					end
					n_hdr_idx = 5'(n_hdr_idx + 5'd1);
				end else if (id_skip_q != 8'd0) begin
					// image id field
					n_id_skip = 8'(id_skip_q - 8'd1);
					if (bytes.file_end) begin
						res        = error_beat(tgad_pkg::ST_TRUNC);
						res_valid  = 1'b1;
						n_finished = 1'b1;
					end
				end else if (kind_q == tgad_pkg::IMG_RLE && pkt_left_q == 8'd0) begin
					// packet header
					n_pkt_run  = data[7];
					n_pkt_left = {1'b0, data[6:0]} + 8'd1;
					if (bytes.file_end) begin
						res        = error_beat(tgad_pkg::ST_TRUNC);
						res_valid  = 1'b1;
						n_finished = 1'b1;
					end
				end else begin
					// pixel bytes, stored b,g,r and alpha taken from the fourth
					if (pix_idx_q == 2'd0) begin
						color_v = '0;
					end
					case (pix_idx_q)
						2'd0:    color_v[7:0]   = data;
						2'd1:    color_v[15:8]  = data;
						2'd2:    color_v[23:16] = data;
						default: ;
					endcase
					n_color = color_v;

					if (idx_inc < bytes_pp) begin
						n_pix_idx = idx_inc[1:0];
						if (bytes.file_end) begin
							res        = error_beat(tgad_pkg::ST_TRUNC);
							res_valid  = 1'b1;
							n_finished = 1'b1;
						end
					end else begin
						n_pix_idx = 2'd0;

						if (kind_q == tgad_pkg::IMG_RLE) begin
							if (pkt_run_q) begin
								cnt        = pkt_left_q;
								n_pkt_left = 8'd0;
							end else begin
								n_pkt_left = 8'(pkt_left_q - 8'd1);
							end
						end
						// clip at the image end
						if ({24'd0, cnt} > pix_left_q) begin
							cnt = pix_left_q[7:0];
						end

						res.status = tgad_pkg::ST_RUN;
						if (bytes_pp == 3'd1) begin
							res.red   = data;
							res.green = data;
							res.blue  = data;
						end else begin
							res.red   = color_v[23:16];
							res.green = color_v[15:8];
							res.blue  = color_v[7:0];
						end
						res.alpha        = (bytes_pp == 3'd4) ? data : tgad_pkg::ALPHA_OPAQUE;
						res.dest_row     = flip_q ? row_q : 16'(height_q - 16'd1 - row_q);
						res.start_column = col_q;
						res.run_count    = cnt;
						res.rows_ascend  = flip_q;
						res.last         = 1'b0;
						res_valid        = 1'b1;

						n_pix_left = 32'(pix_left_q - {24'd0, cnt});
						total      = {1'b0, col_q} + {9'd0, cnt};
						over       = 17'(total - width17);

						if (n_pix_left == 32'd0) begin
							res.last   = 1'b1;
							n_finished = 1'b1;
						end else if (bytes.file_end) begin
							res        = error_beat(tgad_pkg::ST_TRUNC);
							n_finished = 1'b1;
						end else if (total < width17) begin
							n_col = total[15:0];
						end else if (over < width17) begin
							n_row = 16'(row_q + 16'd1);
							n_col = over[15:0];
						end else begin
							// run ends two or more rows on
							n_div_busy = 1'b1;
							n_div_rem  = total;
							n_div_dvs  = {width_q, 7'd0};
							n_div_quo  = '0;
							n_div_cnt  = '0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q  <= '0;
			id_skip_q  <= '0;
			kind_q     <= '0;
			cmap_q     <= '0;
			bpp_q      <= '0;
			flip_q     <= 1'b0;
			width_q    <= '0;
			height_q   <= '0;
			row_q      <= '0;
			col_q      <= '0;
			pix_idx_q  <= '0;
			color_q    <= '0;
			pkt_left_q <= '0;
			pkt_run_q  <= 1'b0;
			finished_q <= 1'b1;
			pix_left_q <= '0;
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			hdr_idx_q  <= n_hdr_idx;
			id_skip_q  <= n_id_skip;
			kind_q     <= n_kind;
			cmap_q     <= n_cmap;
			bpp_q      <= n_bpp;
			flip_q     <= n_flip;
			width_q    <= n_width;
			height_q   <= n_height;
			row_q      <= n_row;
			col_q      <= n_col;
			pix_idx_q  <= n_pix_idx;
			color_q    <= n_color;
			pkt_left_q <= n_pkt_left;
			pkt_run_q  <= n_pkt_run;
			finished_q <= n_finished;
			pix_left_q <= n_pix_left;
			div_busy_q <= n_div_busy;
			div_cnt_q  <= n_div_cnt;
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		div_rem_q <= n_div_rem;
		div_dvs_q <= n_div_dvs;
		div_quo_q <= n_div_quo;
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || runs.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || runs.ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign runs.valid        = out_valid_q;
	assign runs.status       = out_q.status;
	assign runs.red          = out_q.red;
	assign runs.green        = out_q.green;
	assign runs.blue         = out_q.blue;
	assign runs.alpha        = out_q.alpha;
	assign runs.dest_row     = out_q.dest_row;
	assign runs.start_column = out_q.start_column;
	assign runs.run_count    = out_q.run_count;
	assign runs.rows_ascend  = out_q.rows_ascend;
	assign runs.last         = out_q.last;

`ifndef SYNTHESIS
	// a waiting skid entry always sits behind a full output register
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without output entry");

	// no byte is taken while the row wrap divider runs
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> !bytes.ready)
		else $error("byte accepted during row wrap");

	// every error beat closes the file
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != tgad_pkg::ST_RUN |-> out_q.last)
		else $error("error beat without last");

	// column stays inside the image while pixels are being decoded
	assert property (@(posedge clk) disable iff (!arst_n)
		!finished_q && hdr_idx_q == tgad_pkg::HDR_LEN |-> col_q < width_q)
		else $error("column past image width");

	// an open file past its header always has pixels left to come
	assert property (@(posedge clk) disable iff (!arst_n)
		!finished_q && hdr_idx_q == tgad_pkg::HDR_LEN |-> pix_left_q != 32'd0)
		else $error("pixel count exhausted on open file");

	// the divider goes idle once its step count reaches three
	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q && div_cnt_q == 2'd3 |=> !div_busy_q)
		else $error("row wrap overran");
`endif

endmodule
